>>> src/button_debounce_long_press_core_assert.svh
// assertion macros for the button debounce core
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BDLP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BDLP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDLP_ASSERT(lbl, prop, msg)
`define BDLP_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/bdlp_pkg.sv
// shared types and constants for the button debounce core
package bdlp_pkg;

	localparam int IN_BUTTONS = 4;
	localparam int NUM_PAIRS  = 6;
	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EXTRA_LONG = 2'd2;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] EXTRA_LONG_RST = 16'd3000;

	// per-button events of one sample
	typedef struct packed {
		logic pressed;
		logic released;
		logic long_fire;
		logic xlong_fire;
	} bdlp_evt_t;

endpackage

>>> src/bdlp_lane.sv
// one button lane: debounce, press timing and long press detection
module bdlp_lane (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic                          raw,
	input  logic [bdlp_pkg::TIME_W-1:0]   now_ms,
	input  logic [bdlp_pkg::CFG_W-1:0]    debounce_ms,
	input  logic [bdlp_pkg::CFG_W-1:0]    long_thr,
	input  logic [bdlp_pkg::CFG_W-1:0]    xlong_thr,
	output logic                          level_q,
	output logic [bdlp_pkg::TIME_W-1:0]   start_q,
	output bdlp_pkg::bdlp_evt_t           evt_s1
);
	import bdlp_pkg::*;

	logic [TIME_W-1:0] last_q;
	logic              long_q;
	logic              xlong_q;
	logic [TIME_W-1:0] since_chg;
	logic [TIME_W-1:0] held_for;
	logic              chg;
	logic              press;
	logic              level_n;
	logic              lp;
	logic              xl;

	assign since_chg = now_ms - last_q;
	assign held_for  = now_ms - start_q;
	assign chg       = (raw != level_q) && (since_chg > {16'd0, debounce_ms});
	assign press     = chg && raw;
	assign level_n   = chg ? raw : level_q;
	// a fresh press has zero hold time, so it never fires in its own sample
	assign lp = level_n && !press && !long_q && (held_for > {16'd0, long_thr});
	assign xl = level_n && !press && !xlong_q && (held_for > {16'd0, xlong_thr});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			last_q  <= '0;
			start_q <= '0;
			long_q  <= 1'b0;
			xlong_q <= 1'b0;
			evt_s1  <= '0;
		end else if (accept) begin
			level_q <= level_n;
			if (chg) begin
				last_q <= now_ms;
			end
			if (press) begin
				start_q <= now_ms;
				long_q  <= 1'b0;
				xlong_q <= 1'b0;
			end else begin
				long_q  <= long_q | lp;
				xlong_q <= xlong_q | xl;
			end
			evt_s1.pressed    <= press;
			evt_s1.released   <= chg && !raw;
			evt_s1.long_fire  <= lp;
			evt_s1.xlong_fire <= xl;
		end
	end

endmodule

>>> src/bdlp_merge.sv
// merge stage: pair combos, output masks and the output register
module bdlp_merge #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s1_valid,
	input  logic [bdlp_pkg::TIME_W-1:0]             now_s1,
	input  logic [bdlp_pkg::CFG_W-1:0]              xlong_thr,
	input  logic [NUM_BUTTONS-1:0]                  level,
	input  logic [NUM_BUTTONS-1:0][bdlp_pkg::TIME_W-1:0] start,
	input  bdlp_pkg::bdlp_evt_t [NUM_BUTTONS-1:0]   evt,
	input  logic                                    result_stall,
	output logic                                    advance,
	output logic                                    result_valid,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]         held_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]         just_pressed_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]         just_released_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]         long_press_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]         extra_long_mask,
	output logic [bdlp_pkg::NUM_PAIRS-1:0]          combo_long_mask
);
	import bdlp_pkg::*;

	logic [IN_BUTTONS-1:0] held_n;
	logic [IN_BUTTONS-1:0] jp_n;
	logic [IN_BUTTONS-1:0] jr_n;
	logic [IN_BUTTONS-1:0] lp_n;
	logic [IN_BUTTONS-1:0] xl_n;
	logic [NUM_PAIRS-1:0]  combo_n;

	always_comb begin
		held_n = '0;
		jp_n   = '0;
		jr_n   = '0;
		lp_n   = '0;
		xl_n   = '0;
		for (int i = 0; i < IN_BUTTONS; i++) begin
			if (i < NUM_BUTTONS) begin
				held_n[i] = level[i];
				jp_n[i]   = evt[i].pressed;
				jr_n[i]   = evt[i].released;
				lp_n[i]   = evt[i].long_fire;
				xl_n[i]   = evt[i].xlong_fire;
			end
		end
	end

	// pairs numbered in order 01,02,..; only the first NUM_PAIRS (six) fit the mask
	always_comb begin : combo_calc
		int p;
		logic [TIME_W-1:0] later;
		p     = 0;
		later = '0;
		combo_n = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			for (int c = b + 1; c < NUM_BUTTONS; c++) begin
				if (p < NUM_PAIRS) begin
					later = (start[b] > start[c]) ? start[b] : start[c];
					combo_n[p[2:0]] = level[b] && level[c] &&
						((now_s1 - later) > {16'd0, xlong_thr});
				end
				p = p + 1;
			end
		end
	end

	assign advance = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_valid) begin
			held_mask          <= held_n;
			just_pressed_mask  <= jp_n;
			just_released_mask <= jr_n;
			long_press_mask    <= lp_n;
			extra_long_mask    <= xl_n;
			combo_long_mask    <= combo_n;
		end
	end

endmodule

>>> src/button_debounce_long_press_core.sv
// top level of the four button debouncer with long press and pair combos
// Usage:
//  - sample channel: sample_valid/sample_stall carry raw_levels and now_ms,
//    one word per cycle; a word is taken when valid is high and stall is low
//  - result channel: result_valid/result_stall carry the six masks, one
//    result word for every sample word, in order
//  - config channel: cfg_valid/cfg_ready, cfg_index 0 debounce, 1 long press,
//    2 extra long press; other indexes are ignored; cfg_ready is always high;
//    write only while no sample is in flight
//  - path: a sample word is registered in the lane stage and then in the
//    output register, where it waits while result_stall is high
//  - throughput: one sample per cycle while sample_stall is low; the per-button
//    state update in the lanes finishes within the accepting cycle, which sets that figure
//  - stall: the lane stage holds one word and the output register one more;
//    sample_stall rises only when both are full and result_stall is high
//  - reset: all buttons released, times zero, thresholds 50, 1000, 3000 ms,
//    both stages empty
`include "button_debounce_long_press_core_assert.svh"
module button_debounce_long_press_core #(
	parameter int NUM_BUTTONS = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [bdlp_pkg::IN_BUTTONS-1:0]   raw_levels,
	input  logic [bdlp_pkg::TIME_W-1:0]       now_ms,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]   held_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]   just_pressed_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]   just_released_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]   long_press_mask,
	output logic [bdlp_pkg::IN_BUTTONS-1:0]   extra_long_mask,
	output logic [bdlp_pkg::NUM_PAIRS-1:0]    combo_long_mask,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bdlp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bdlp_pkg::CFG_W-1:0]        cfg_data
);
	import bdlp_pkg::*;

	logic [CFG_W-1:0]  debounce_q;
	logic [CFG_W-1:0]  long_press_q;
	logic [CFG_W-1:0]  extra_long_q;
	logic              valid_s1;
	logic [TIME_W-1:0] now_s1;
	logic              accept;
	logic              advance;

	logic [NUM_BUTTONS-1:0]             level;
	logic [NUM_BUTTONS-1:0][TIME_W-1:0] start;
	bdlp_evt_t [NUM_BUTTONS-1:0]        evt;

	assign cfg_ready    = 1'b1;
	assign sample_stall = valid_s1 && !advance;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			extra_long_q <= EXTRA_LONG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DEBOUNCE:   debounce_q   <= cfg_data;
				CFG_LONG_PRESS: long_press_q <= cfg_data;
				CFG_EXTRA_LONG: extra_long_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// lane state already holds the post-update values of the word in s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_s1 <= now_ms;
		end
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		logic raw_bit;
		if (g < IN_BUTTONS) begin : g_pin
			assign raw_bit = raw_levels[g];
		end else begin : g_nopin
			assign raw_bit = 1'b0;
		end
		bdlp_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.accept      (accept),
			.raw         (raw_bit),
			.now_ms      (now_ms),
			.debounce_ms (debounce_q),
			.long_thr    (long_press_q),
			.xlong_thr   (extra_long_q),
			.level_q     (level[g]),
			.start_q     (start[g]),
			.evt_s1      (evt[g])
		);
	end

	bdlp_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.clk                 (clk),
		.arst_n              (arst_n),
		.s1_valid            (valid_s1),
		.now_s1              (now_s1),
		.xlong_thr           (extra_long_q),
		.level               (level),
		.start               (start),
		.evt                 (evt),
		.result_stall        (result_stall),
		.advance             (advance),
		.result_valid        (result_valid),
		.held_mask           (held_mask),
		.just_pressed_mask   (just_pressed_mask),
		.just_released_mask  (just_released_mask),
		.long_press_mask     (long_press_mask),
		.extra_long_mask     (extra_long_mask),
		.combo_long_mask     (combo_long_mask)
	);

	`BDLP_ASSERT(a_stall_only_when_full, sample_stall |-> (valid_s1 && result_valid && result_stall), "sample stalled with room in the pipeline")
	`BDLP_ASSERT(a_press_release_disjoint, result_valid |-> ((just_pressed_mask & just_released_mask) == '0), "press and release in one word")
	`BDLP_ASSERT(a_press_is_held, result_valid |-> ((just_pressed_mask & ~held_mask) == '0), "press reported for a released button")
	`BDLP_ASSERT(a_long_is_held, result_valid |-> (((long_press_mask | extra_long_mask) & ~held_mask) == '0), "long press on a released button")
	`BDLP_ASSERT(a_s1_drains, (valid_s1 && !result_valid) |=> result_valid, "lane stage word not moved to the output")

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the four button debounce and long press core
module tb_top;
	import bdlp_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int PIPE_LAT    = 2;
	localparam int NUM_PHASES  = 5;
	localparam int PHASE_ITEMS = 400;

	typedef struct packed {
		logic [IN_BUTTONS-1:0] held;
		logic [IN_BUTTONS-1:0] pressed;
		logic [IN_BUTTONS-1:0] released;
		logic [IN_BUTTONS-1:0] long_fire;
		logic [IN_BUTTONS-1:0] xlong_fire;
		logic [NUM_PAIRS-1:0]  combo;
	} masks_t;

	typedef struct {
		bit                    is_cfg;
		logic [CFG_W-1:0]      dbn;
		logic [CFG_W-1:0]      lng;
		logic [CFG_W-1:0]      xlg;
		logic [IN_BUTTONS-1:0] raw;
		logic [TIME_W-1:0]     now;
		bit                    has_want;
		masks_t                want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	logic [IN_BUTTONS-1:0] raw_levels = '0;
	logic [TIME_W-1:0]     now_ms = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [IN_BUTTONS-1:0] held_mask;
	logic [IN_BUTTONS-1:0] just_pressed_mask;
	logic [IN_BUTTONS-1:0] just_released_mask;
	logic [IN_BUTTONS-1:0] long_press_mask;
	logic [IN_BUTTONS-1:0] extra_long_mask;
	logic [NUM_PAIRS-1:0]  combo_long_mask;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	button_debounce_long_press_core dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.sample_valid       (sample_valid),
		.sample_stall       (sample_stall),
		.raw_levels         (raw_levels),
		.now_ms             (now_ms),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.held_mask          (held_mask),
		.just_pressed_mask  (just_pressed_mask),
		.just_released_mask (just_released_mask),
		.long_press_mask    (long_press_mask),
		.extra_long_mask    (extra_long_mask),
		.combo_long_mask    (combo_long_mask),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	// debouncer state mirrored by the predictor
	logic [CFG_W-1:0]  dbn_ms;
	logic [CFG_W-1:0]  lng_ms;
	logic [CFG_W-1:0]  xlg_ms;
	logic              btn_level [IN_BUTTONS];
	logic [TIME_W-1:0] last_chg [IN_BUTTONS];
	logic [TIME_W-1:0] press_t [IN_BUTTONS];
	logic              lp_done [IN_BUTTONS];
	logic              xl_done [IN_BUTTONS];

	masks_t   pending_masks [$];
	masks_t   got_want;
	dir_row_t dir_rows [$];

	int idle_pct = 0;
	int stall_pct = 0;
	int n_err = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_cfg_writes = 0;
	int n_settings = 0;
	logic [IN_BUTTONS-1:0] cur_raw = '0;
	logic [TIME_W-1:0]     cur_now = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic masks_t mk(logic [3:0] h, logic [3:0] p, logic [3:0] r,
		logic [3:0] l, logic [3:0] x, logic [5:0] c);
		masks_t m;
		m.held = h;
		m.pressed = p;
		m.released = r;
		m.long_fire = l;
		m.xlong_fire = x;
		m.combo = c;
		return m;
	endfunction

	function void add_cfg(int d, int l, int x);
		dir_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.dbn = CFG_W'(d);
		row.lng = CFG_W'(l);
		row.xlg = CFG_W'(x);
		dir_rows.push_back(row);
	endfunction

	function void add_row(logic [3:0] raw, logic [31:0] now, bit has_want, masks_t want);
		dir_row_t row;
		row = '{default: '0};
		row.raw = raw;
		row.now = now;
		row.has_want = has_want;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	function void model_reset();
		dbn_ms = DEBOUNCE_RST;
		lng_ms = LONG_PRESS_RST;
		xlg_ms = EXTRA_LONG_RST;
		for (int b = 0; b < IN_BUTTONS; b++) begin
			btn_level[b] = 1'b0;
			last_chg[b] = '0;
			press_t[b] = '0;
			lp_done[b] = 1'b0;
			xl_done[b] = 1'b0;
		end
	endfunction

	function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			CFG_DEBOUNCE:   dbn_ms = data;
			CFG_LONG_PRESS: lng_ms = data;
			CFG_EXTRA_LONG: xlg_ms = data;
			default: ;
		endcase
	endfunction

	function automatic masks_t predict_sample(logic [IN_BUTTONS-1:0] raw, logic [TIME_W-1:0] now);
		masks_t m;
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] start;
		int pb;
		m = '0;
		pb = 0;
		for (int b = 0; b < IN_BUTTONS; b++) begin
			elapsed = now - last_chg[b];
			if (raw[b] != btn_level[b] && elapsed > TIME_W'(dbn_ms)) begin
				last_chg[b] = now;
				btn_level[b] = raw[b];
				if (raw[b]) begin
					press_t[b] = now;
					lp_done[b] = 1'b0;
					xl_done[b] = 1'b0;
					m.pressed[b] = 1'b1;
				end else begin
					m.released[b] = 1'b1;
				end
			end
			// long checks see the level after this sample's debounce update
			if (btn_level[b]) begin
				elapsed = now - press_t[b];
				if (!lp_done[b] && elapsed > TIME_W'(lng_ms)) begin
					lp_done[b] = 1'b1;
					m.long_fire[b] = 1'b1;
				end
				if (!xl_done[b] && elapsed > TIME_W'(xlg_ms)) begin
					xl_done[b] = 1'b1;
					m.xlong_fire[b] = 1'b1;
				end
				m.held[b] = 1'b1;
			end
		end
		for (int b = 0; b < IN_BUTTONS; b++) begin
			for (int c = b + 1; c < IN_BUTTONS; c++) begin
				if (btn_level[b] && btn_level[c]) begin
					// later start by plain unsigned compare, no wrap awareness
					start = (press_t[b] > press_t[c]) ? press_t[b] : press_t[c];
					elapsed = now - start;
					if (elapsed > TIME_W'(xlg_ms))
						m.combo[pb] = 1'b1;
				end
				pb++;
			end
		end
		return m;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("ERROR %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		n_err++;
	endtask

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (pending_masks.size() == 0) begin
				report_mismatch("result word with nothing pending", 32'(held_mask), 0);
			end else begin
				got_want = pending_masks.pop_front();
				if (held_mask !== got_want.held)
					report_mismatch("held_mask", 32'(held_mask), 32'(got_want.held));
				if (just_pressed_mask !== got_want.pressed)
					report_mismatch("just_pressed_mask", 32'(just_pressed_mask),
						32'(got_want.pressed));
				if (just_released_mask !== got_want.released)
					report_mismatch("just_released_mask", 32'(just_released_mask),
						32'(got_want.released));
				if (long_press_mask !== got_want.long_fire)
					report_mismatch("long_press_mask", 32'(long_press_mask),
						32'(got_want.long_fire));
				if (extra_long_mask !== got_want.xlong_fire)
					report_mismatch("extra_long_mask", 32'(extra_long_mask),
						32'(got_want.xlong_fire));
				if (combo_long_mask !== got_want.combo)
					report_mismatch("combo_long_mask", 32'(combo_long_mask),
						32'(got_want.combo));
			end
		end
	end

	task automatic send_sample(logic [IN_BUTTONS-1:0] raw, logic [TIME_W-1:0] now,
		bit use_want, masks_t want);
		masks_t m;
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			sample_valid <= 1'b0;
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		raw_levels <= raw;
		now_ms <= now;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		m = predict_sample(raw, now);
		pending_masks.push_back(use_want ? want : m);
		n_samples++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (pending_masks.size() != 0) @(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_cfg(idx, data);
		n_cfg_writes++;
	endtask

	task automatic load_thresholds(logic [CFG_W-1:0] d, logic [CFG_W-1:0] l, logic [CFG_W-1:0] x);
		wait_idle();
		// unmapped index must leave every threshold alone
		write_reg(CFG_UNUSED, CFG_W'($urandom));
		write_reg(CFG_DEBOUNCE, d);
		write_reg(CFG_LONG_PRESS, l);
		write_reg(CFG_EXTRA_LONG, x);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic run_random(int n, int dmax, bit pause_mid);
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2)
				wait_idle();
			case ($urandom_range(19))
				0: cur_now = $urandom;
				1: cur_raw = IN_BUTTONS'($urandom);
				default: begin
					cur_now = cur_now + TIME_W'($urandom_range(dmax));
					for (int b = 0; b < IN_BUTTONS; b++)
						if ($urandom_range(99) < 12)
							cur_raw[b] = ~cur_raw[b];
				end
			endcase
			send_sample(cur_raw, cur_now, 1'b0, '0);
		end
	endtask

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		model_reset();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// power-up thresholds 50, 1000, 3000
		add_row(4'hF, 32'd0, 1, mk(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 6'h00));
		add_row(4'hF, 32'd50, 1, mk(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 6'h00));
		add_row(4'hF, 32'd51, 1, mk(4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 6'h00));
		add_row(4'hF, 32'd1052, 1, mk(4'hF, 4'h0, 4'h0, 4'hF, 4'h0, 6'h00));
		add_row(4'hF, 32'd3052, 1, mk(4'hF, 4'h0, 4'h0, 4'h0, 4'hF, 6'h3F));
		add_row(4'h0, 32'd3060, 1, mk(4'h0, 4'h0, 4'hF, 4'h0, 4'h0, 6'h00));
		add_row(4'h1, 32'd3100, 1, mk(4'h0, 4'h0, 4'h0, 4'h0, 4'h0, 6'h00));
		add_row(4'h1, 32'd3111, 1, mk(4'h1, 4'h1, 4'h0, 4'h0, 4'h0, 6'h00));
		add_row(4'h3, 32'd3200, 1, mk(4'h3, 4'h2, 4'h0, 4'h0, 4'h0, 6'h00));
		add_row(4'h0, 32'hFFFF_FFFF, 0, '0);
		// zero thresholds: any nonzero elapsed time counts
		add_cfg(0, 0, 0);
		add_row(4'h1, 32'd100, 0, '0);
		add_row(4'h1, 32'd101, 0, '0);
		add_row(4'h0, 32'd101, 0, '0);
		add_row(4'h0, 32'd102, 0, '0);
		add_cfg(65535, 65535, 65535);
		add_row(4'hF, 32'd65637, 0, '0);
		add_row(4'hF, 32'h0002_0000, 0, '0);
		add_row(4'hA, 32'h8000_0000, 0, '0);
		// pair started across the timestamp wrap
		add_cfg(DEBOUNCE_RST, LONG_PRESS_RST, EXTRA_LONG_RST);
		add_row(4'h0, 32'hFFFF_E000, 0, '0);
		add_row(4'h1, 32'hFFFF_F000, 0, '0);
		add_row(4'h3, 32'h0000_0010, 0, '0);
		add_row(4'h3, 32'h0000_0800, 0, '0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg)
				load_thresholds(dir_rows[i].dbn, dir_rows[i].lng, dir_rows[i].xlg);
			else
				send_sample(dir_rows[i].raw, dir_rows[i].now, dir_rows[i].has_want,
					dir_rows[i].want);
		end

		cur_now = 32'hFFFF_0000;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: load_thresholds(CFG_W'($urandom_range(20)), CFG_W'($urandom_range(150)),
					CFG_W'($urandom_range(400)));
				1: load_thresholds('0, '0, '0);
				2: load_thresholds('1, '1, '1);
				3: load_thresholds(CFG_W'($urandom_range(20)), CFG_W'($urandom_range(150)),
					CFG_W'($urandom_range(400)));
				default: load_thresholds(CFG_W'($urandom_range(200)),
					CFG_W'($urandom_range(2000)), CFG_W'($urandom_range(6000)));
			endcase
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  run_random(PHASE_ITEMS, 40, 0);    end
				1: begin idle_pct = 71; stall_pct = 0;  run_random(PHASE_ITEMS, 3, 0);     end
				2: begin idle_pct = 0;  stall_pct = 71; run_random(PHASE_ITEMS, 40000, 0); end
				3: begin idle_pct = 36; stall_pct = 36; run_random(PHASE_ITEMS, 40, 1);    end
				default: begin idle_pct = 0; stall_pct = 0; run_random(PHASE_ITEMS, 300, 0); end
			endcase
		end

		wait_idle();
		$display("covered %0d sample words and %0d result words, %0d register writes",
			n_samples, n_results, n_cfg_writes);
		$display("over %0d threshold settings with idle and stall mixes; %0d mismatches",
			n_settings, n_err);
		if (n_err == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
